### rtl/ctkt_pkg.sv
`default_nettype none
// Types and constants for the capacitive touch key tracker.
// No dependencies.
package ctkt_pkg;

    typedef enum logic [3:0] {
        NS_CAL   = 4'd0,
        NS_IDLE  = 4'd1,
        NS_LOW   = 4'd2,
        NS_HIGH  = 4'd3,
        NS_TIN   = 4'd4,
        NS_TOUCH = 4'd5,
        NS_TOUT  = 4'd6,
        NS_RECAL = 4'd7,
        NS_ERR   = 4'd8
    } t_node_st;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CAL_DONE = 3'd1,
        EV_CAL_ERR  = 3'd2,
        EV_TOUCH    = 3'd3,
        EV_RELEASE  = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        CFG_MUTUAL    = 3'd0,
        CFG_TIN_THR   = 3'd1,
        CFG_TOUT_THR  = 3'd2,
        CFG_TCONFIRM  = 3'd3,
        CFG_RCONFIRM  = 3'd4,
        CFG_TMAX      = 3'd5,
        CFG_DRIFT_UP  = 3'd6,
        CFG_DRIFT_DN  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CAL_BUSY = 2'd0,
        CAL_DONE = 2'd1,
        CAL_FAIL = 2'd2
    } t_cal_rc;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_OUTER,
        CS_ROUGH,
        CS_COARSE,
        CS_CFIX,
        CS_FINE,
        CS_FFIX
    } t_cal_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CAL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        done;
        t_cal_rc     rc;
        logic [15:0] comp;
    } t_cal_res;

    typedef struct packed {
        logic [3:0] node_index;
        logic [9:0] sensor_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  node_out;
        logic [3:0]  node_status;
        logic [2:0]  event_code;
        logic [15:0] reference_out;
        logic [15:0] compensation_out;
        logic        touched;
    } t_out_item;

    localparam logic [9:0]  CAL_MID      = 10'h1FF;
    localparam logic [9:0]  CAL_TOL      = 10'd10;
    localparam logic [9:0]  STEP_ROUGH   = 10'h0CF;
    localparam logic [9:0]  STEP_COARSE  = 10'h015;
    localparam logic [9:0]  STEP_FINE    = 10'd2;
    localparam logic [9:0]  STEP_ADDR    = 10'h0F0;
    localparam logic [9:0]  ADDR_LIMIT   = 10'h100;
    localparam logic [7:0]  ADDR_INC     = 8'h40;
    localparam logic [7:0]  ADDR_TOP     = 8'hC0;
    localparam logic [15:0] COMP_MUTUAL  = 16'h0234;
    localparam logic [15:0] COMP_SELF    = 16'h0567;
    localparam logic [7:0]  CAL_MAX_TRY  = 8'd10;
    localparam logic [7:0]  RECAL_DWELL  = 8'd3;
    localparam logic [17:0] REF_MID      = 18'd512;

endpackage

`default_nettype wire

### rtl/ctkt_cal.sv
`default_nettype none
// Calibration sequencer: steps the compensation fields by repeated subtraction, at most one subtraction per cycle.
// Depends on ctkt_pkg.
module ctkt_cal (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_mutual,
    input  wire logic [9:0]        i_raw,
    input  wire logic [15:0]       i_comp,
    output ctkt_pkg::t_cal_res     o_res
);

    ctkt_pkg::t_cal_state r_state, n_state;
    ctkt_pkg::t_cal_res   r_res, n_res;
    logic [9:0] r_r, n_r;
    logic [7:0] r_rough, n_rough, r_coarse, n_coarse, r_fine, n_fine, r_addr, n_addr;
    logic [3:0] r_acc, n_acc;
    logic [7:0] r_dir, n_dir, r_ovf, n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ctkt_pkg::CS_IDLE;
            r_res    <= '0;
        end else begin
            r_state  <= n_state;
            r_res    <= n_res;
        end
        r_r      <= n_r;
        r_rough  <= n_rough;
        r_coarse <= n_coarse;
        r_fine   <= n_fine;
        r_addr   <= n_addr;
        r_acc    <= n_acc;
        r_dir    <= n_dir;
        r_ovf    <= n_ovf;
    end

    always_comb begin
        logic       hiside, up;
        logic [9:0] r0;
        logic [7:0] t, c2;
        n_state  = r_state;
        n_res    = r_res;
        n_res.done = 1'b0;
        n_r      = r_r;
        n_rough  = r_rough;
        n_coarse = r_coarse;
        n_fine   = r_fine;
        n_addr   = r_addr;
        n_acc    = r_acc;
        n_dir    = r_dir;
        n_ovf    = r_ovf;
        hiside   = i_raw > ctkt_pkg::CAL_MID;
        r0       = hiside ? i_raw - ctkt_pkg::CAL_MID : ctkt_pkg::CAL_MID - i_raw;
        up       = hiside ? !i_mutual : i_mutual;
        t        = '0;
        c2       = '0;
        case (r_state)
            ctkt_pkg::CS_IDLE: begin
                if (i_start) begin
                    n_acc    = i_comp[3:0];
                    n_fine   = {4'b0, i_comp[7:4]};
                    n_coarse = {4'b0, i_comp[11:8]};
                    n_rough  = {6'b0, i_comp[13:12]};
                    n_addr   = {i_comp[15:14], 6'b0};
                    n_res.comp = i_comp;
                    n_dir    = up ? 8'h01 : 8'hFF;
                    n_ovf    = up ? 8'h06 : 8'hFA;
                    n_r      = r0;
                    if (r0 < ctkt_pkg::CAL_TOL) begin
                        n_res.done = 1'b1;
                        n_res.rc   = ctkt_pkg::CAL_DONE;
                    end else begin
                        if (i_mutual) begin
                            n_r = r0 >> 1;
                        end else if (r0 > ctkt_pkg::ADDR_LIMIT) begin
                            if (hiside && n_addr < ctkt_pkg::ADDR_TOP) begin
                                n_addr = n_addr + ctkt_pkg::ADDR_INC;
                                n_r    = r0 - ctkt_pkg::STEP_ADDR;
                            end else if (!hiside && n_addr >= ctkt_pkg::ADDR_INC) begin
                                n_addr = n_addr - ctkt_pkg::ADDR_INC;
                                n_r    = r0 - ctkt_pkg::STEP_ADDR;
                            end
                        end
                        n_state = ctkt_pkg::CS_OUTER;
                    end
                end
            end
            ctkt_pkg::CS_OUTER: begin
                if (r_r > 10'd1) begin
                    n_state = ctkt_pkg::CS_ROUGH;
                end else begin
                    n_res.done = 1'b1;
                    n_res.rc   = ctkt_pkg::CAL_BUSY;
                    n_res.comp = {({r_rough[3:0], 4'b0} | r_addr | r_coarse),
                                  r_fine[3:0], r_acc};
                    n_state    = ctkt_pkg::CS_IDLE;
                end
            end
            ctkt_pkg::CS_ROUGH: begin
                t = r_rough + r_dir;
                if (r_r > ctkt_pkg::STEP_ROUGH && t <= 8'd3) begin
                    n_rough = t;
                    n_r     = r_r - ctkt_pkg::STEP_ROUGH;
                end else begin
                    n_state = ctkt_pkg::CS_COARSE;
                end
            end
            ctkt_pkg::CS_COARSE: begin
                t = r_coarse + r_dir;
                if (r_r > ctkt_pkg::STEP_COARSE) begin
                    n_coarse = t;
                    if (t > 8'h0F) n_state = ctkt_pkg::CS_CFIX;
                    else n_r = r_r - ctkt_pkg::STEP_COARSE;
                end else begin
                    n_state = ctkt_pkg::CS_CFIX;
                end
            end
            ctkt_pkg::CS_CFIX: begin
                t = r_rough + r_dir;
                if (r_coarse > 8'h0F) begin
                    if (t > 8'd3) begin
                        n_coarse = r_coarse - r_dir;
                    end else begin
                        n_rough  = t;
                        n_coarse = r_coarse - r_ovf;
                    end
                end
                n_state = ctkt_pkg::CS_FINE;
            end
            ctkt_pkg::CS_FINE: begin
                t = r_fine + r_dir;
                if (r_r > 10'd1) begin
                    n_fine = t;
                    if (t > 8'h0F) n_state = ctkt_pkg::CS_FFIX;
                    else n_r = r_r - ctkt_pkg::STEP_FINE;
                end else begin
                    n_state = ctkt_pkg::CS_FFIX;
                end
            end
            ctkt_pkg::CS_FFIX: begin
                t  = r_rough + r_dir;
                c2 = r_coarse + r_dir;
                n_state = ctkt_pkg::CS_OUTER;
                if (r_fine > 8'h0F) begin
                    if (c2 > 8'h0F) begin
                        if (t > 8'd3) begin
                            n_res.done = 1'b1;
                            n_res.rc   = ctkt_pkg::CAL_FAIL;
                            n_state    = ctkt_pkg::CS_IDLE;
                        end else begin
                            n_rough  = t;
                            n_coarse = c2 - r_ovf;
                        end
                    end else begin
                        n_coarse = c2;
                        n_fine   = r_fine - r_ovf;
                    end
                end
            end
            default: n_state = ctkt_pkg::CS_IDLE;
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### rtl/capacitive_touch_key_tracker.sv
`default_nettype none
// Capacitive touch key tracker top level: per-node state tables and detection logic.
// Depends on ctkt_pkg and ctkt_cal.
//
// One transaction carries one measurement for one node and yields one result.
// For a calibrated node the transaction passes through evaluation, then
// write-back, where the result is registered; the input is ready again in the
// same cycle that the result becomes valid. A calibrating node adds the
// calibration sequencer's rough (207 counts), coarse (21 counts) and fine
// (2 counts) steps, plus a check state and fix-up states in each pass.
// The input is ready only in idle; a result waiting at the output holds the
// write-back until it is taken.
module capacitive_touch_key_tracker #(
    parameter int NODE_COUNT  = 16,
    parameter int RECAL_DELTA = 150
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ctkt_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ctkt_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [8:0]          i_cfg_data
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic signed [17:0] NEG_RD = 18'(-RECAL_DELTA);
    localparam logic signed [17:0] REF_LO = 18'(512 - RECAL_DELTA);
    localparam logic signed [17:0] REF_HI = 18'(512 + RECAL_DELTA);

    logic [3:0]  mem_st   [NODE_COUNT];
    logic [7:0]  mem_dw   [NODE_COUNT];
    logic [15:0] mem_ref  [NODE_COUNT];
    logic [15:0] mem_comp [NODE_COUNT];

    ctkt_pkg::t_state r_state, n_state;
    logic            r_mutual;
    logic [8:0]      r_tin, r_tout;
    logic [7:0]      r_tconf, r_rconf, r_tmax, r_dup, r_ddn;
    logic [NODE_COUNT-1:0] r_started;
    logic [3:0]      r_q_st;
    logic [7:0]      r_q_dw;
    logic [15:0]     r_q_ref, r_q_comp;
    logic [3:0]      r_node;
    logic [9:0]      r_s;
    logic            r_bad, n_bad;
    ctkt_pkg::t_node_st r_st, n_st, r_nst, n_nst;
    ctkt_pkg::t_event   r_ev, n_ev;
    logic [7:0]      r_dw, n_dw;
    logic [15:0]     r_ref, n_ref, r_comp, n_comp;
    logic            r_ovalid, n_ovalid;
    ctkt_pkg::t_out_item r_out, n_out;
    logic            cal_start;
    ctkt_pkg::t_cal_res cal_res;
    logic            in_go, fin_go, started;
    logic [AW-1:0]   in_addr, addr;
    logic [7:0]      wb_dw;

    assign in_go   = i_in_valid && o_in_ready;
    assign fin_go  = (r_state == ctkt_pkg::S_FIN) && (!r_ovalid || i_out_ready);
    assign in_addr = AW'(i_in_data.node_index);
    assign addr    = AW'(r_node);
    assign started = r_started[addr];

    ctkt_cal u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cal_start),
        .i_mutual (r_mutual),
        .i_raw    (r_s),
        .i_comp   (started ? r_q_comp
                           : (r_mutual ? ctkt_pkg::COMP_MUTUAL : ctkt_pkg::COMP_SELF)),
        .o_res    (cal_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mutual <= 1'b0;
            r_tin    <= 9'd20;
            r_tout   <= 9'd10;
            r_tconf  <= 8'd3;
            r_rconf  <= 8'd3;
            r_tmax   <= 8'd200;
            r_dup    <= 8'd15;
            r_ddn    <= 8'd15;
        end else if (i_cfg_we) begin
            case (ctkt_pkg::t_cfg_idx'(i_cfg_idx))
                ctkt_pkg::CFG_MUTUAL:   r_mutual <= i_cfg_data[0];
                ctkt_pkg::CFG_TIN_THR:  r_tin    <= i_cfg_data;
                ctkt_pkg::CFG_TOUT_THR: r_tout   <= i_cfg_data;
                ctkt_pkg::CFG_TCONFIRM: r_tconf  <= i_cfg_data[7:0];
                ctkt_pkg::CFG_RCONFIRM: r_rconf  <= i_cfg_data[7:0];
                ctkt_pkg::CFG_TMAX:     r_tmax   <= i_cfg_data[7:0];
                ctkt_pkg::CFG_DRIFT_UP: r_dup    <= i_cfg_data[7:0];
                ctkt_pkg::CFG_DRIFT_DN: r_ddn    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ctkt_pkg::S_IDLE;
            r_ovalid  <= 1'b0;
            r_started <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (fin_go && !r_bad) r_started[addr] <= 1'b1;
        end
        r_bad  <= n_bad;
        r_st   <= n_st;
        r_nst  <= n_nst;
        r_ev   <= n_ev;
        r_dw   <= n_dw;
        r_ref  <= n_ref;
        r_comp <= n_comp;
        r_out  <= n_out;
        if (in_go) begin
            r_node <= i_in_data.node_index;
            r_s    <= i_in_data.sensor_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_st   <= mem_st[in_addr];
        r_q_dw   <= mem_dw[in_addr];
        r_q_ref  <= mem_ref[in_addr];
        r_q_comp <= mem_comp[in_addr];
        if (fin_go && !r_bad) begin
            mem_st[addr]   <= r_nst;
            mem_dw[addr]   <= wb_dw;
            mem_ref[addr]  <= r_ref;
            mem_comp[addr] <= r_comp;
        end
    end

    assign wb_dw = (r_st != ctkt_pkg::NS_ERR && r_nst != ctkt_pkg::NS_ERR)
                 ? ((r_nst != r_st) ? 8'd0 : r_dw + 8'd1) : r_dw;

    always_comb begin
        ctkt_pkg::t_node_st st;
        logic [7:0]         dw;
        logic signed [17:0] d, refs, tin, tout;
        n_state   = r_state;
        n_bad     = r_bad;
        n_st      = r_st;
        n_nst     = r_nst;
        n_ev      = r_ev;
        n_dw      = r_dw;
        n_ref     = r_ref;
        n_comp    = r_comp;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_out     = r_out;
        cal_start = 1'b0;
        st   = started ? ctkt_pkg::t_node_st'(r_q_st) : ctkt_pkg::NS_CAL;
        dw   = started ? r_q_dw : 8'd0;
        refs = signed'({2'b0, r_q_ref});
        d    = signed'({8'b0, r_s}) - refs;
        tin  = signed'({9'b0, r_tin});
        tout = signed'({9'b0, r_tout});
        case (r_state)
            ctkt_pkg::S_IDLE: begin
                if (in_go) begin
                    n_bad   = int'(i_in_data.node_index) >= NODE_COUNT;
                    n_state = n_bad ? ctkt_pkg::S_FIN : ctkt_pkg::S_EVAL;
                end
            end
            ctkt_pkg::S_EVAL: begin
                n_st   = st;
                n_dw   = dw;
                n_ref  = started ? r_q_ref : 16'd0;
                n_comp = started ? r_q_comp
                       : (r_mutual ? ctkt_pkg::COMP_MUTUAL : ctkt_pkg::COMP_SELF);
                n_ev   = ctkt_pkg::EV_NONE;
                n_nst  = st;
                n_state = ctkt_pkg::S_FIN;
                case (st)
                    ctkt_pkg::NS_CAL: begin
                        cal_start = 1'b1;
                        n_state   = ctkt_pkg::S_CAL;
                    end
                    ctkt_pkg::NS_RECAL: begin
                        if (d > NEG_RD) n_nst = ctkt_pkg::NS_IDLE;
                        else if (dw > ctkt_pkg::RECAL_DWELL) n_nst = ctkt_pkg::NS_CAL;
                    end
                    ctkt_pkg::NS_LOW: begin
                        if (d > 18'sd0) n_nst = ctkt_pkg::NS_IDLE;
                        else if (d < NEG_RD) n_nst = ctkt_pkg::NS_RECAL;
                        else if (dw > r_ddn) begin
                            n_ref = r_q_ref - 16'd1;
                            n_nst = ctkt_pkg::NS_IDLE;
                        end
                    end
                    ctkt_pkg::NS_IDLE: begin
                        if (d < NEG_RD) n_nst = ctkt_pkg::NS_RECAL;
                        else if (d >= tin) n_nst = ctkt_pkg::NS_TIN;
                        else if (refs <= REF_LO) n_nst = ctkt_pkg::NS_CAL;
                        else if (refs >= REF_HI) n_nst = ctkt_pkg::NS_CAL;
                        else if (d < -18'sd1) n_nst = ctkt_pkg::NS_LOW;
                        else if (d > 18'sd1) n_nst = ctkt_pkg::NS_HIGH;
                    end
                    ctkt_pkg::NS_HIGH: begin
                        if (d < 18'sd0) n_nst = ctkt_pkg::NS_IDLE;
                        else if (d >= tin) n_nst = ctkt_pkg::NS_TIN;
                        else if (dw > r_dup) begin
                            n_ref = r_q_ref + 16'd1;
                            n_nst = ctkt_pkg::NS_IDLE;
                        end
                    end
                    ctkt_pkg::NS_TIN: begin
                        if (dw >= r_tconf) begin
                            n_nst = ctkt_pkg::NS_TOUCH;
                            n_ev  = ctkt_pkg::EV_TOUCH;
                        end else if (d < tin) n_nst = ctkt_pkg::NS_IDLE;
                    end
                    ctkt_pkg::NS_TOUT: begin
                        if (dw >= r_rconf) begin
                            n_nst = ctkt_pkg::NS_IDLE;
                            n_ev  = ctkt_pkg::EV_RELEASE;
                        end else if (d > tin) n_nst = ctkt_pkg::NS_TOUCH;
                    end
                    ctkt_pkg::NS_TOUCH: begin
                        if (dw > r_tmax) n_nst = ctkt_pkg::NS_CAL;
                        else if (d < tout) n_nst = ctkt_pkg::NS_TOUT;
                    end
                    default: n_nst = ctkt_pkg::NS_ERR;
                endcase
            end
            ctkt_pkg::S_CAL: begin
                if (cal_res.done) begin
                    n_state = ctkt_pkg::S_FIN;
                    case (cal_res.rc)
                        ctkt_pkg::CAL_DONE: begin
                            n_ref = {6'b0, r_s};
                            n_nst = ctkt_pkg::NS_IDLE;
                            n_ev  = ctkt_pkg::EV_CAL_DONE;
                        end
                        ctkt_pkg::CAL_FAIL: begin
                            n_nst = ctkt_pkg::NS_ERR;
                            n_ev  = ctkt_pkg::EV_CAL_ERR;
                        end
                        default: begin
                            n_comp = cal_res.comp;
                            if (r_dw > ctkt_pkg::CAL_MAX_TRY) begin
                                n_nst = ctkt_pkg::NS_ERR;
                                n_ev  = ctkt_pkg::EV_CAL_ERR;
                            end
                        end
                    endcase
                end
            end
            ctkt_pkg::S_FIN: begin
                if (fin_go) begin
                    n_ovalid = 1'b1;
                    n_state  = ctkt_pkg::S_IDLE;
                    n_out.node_out = r_node;
                    if (r_bad) begin
                        n_out.node_status      = ctkt_pkg::NS_ERR;
                        n_out.event_code       = ctkt_pkg::EV_NONE;
                        n_out.reference_out    = '0;
                        n_out.compensation_out = '0;
                        n_out.touched          = 1'b0;
                    end else begin
                        n_out.node_status      = r_nst;
                        n_out.event_code       = r_ev;
                        n_out.reference_out    = r_ref;
                        n_out.compensation_out = r_comp;
                        n_out.touched          = (r_nst == ctkt_pkg::NS_TOUCH) ||
                                                 (r_nst == ctkt_pkg::NS_TOUT);
                    end
                end
            end
            default: n_state = ctkt_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ctkt_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### bench/capacitive_touch_key_tracker_test.sv
// Self-checking bench for capacitive_touch_key_tracker: directed and random
// measurements, predicted per node by a scoreboard class, under valid/ready stalls.
// Depends on ctkt_pkg and the RTL of capacitive_touch_key_tracker.
module capacitive_touch_key_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    class touch_scoreboard;
        logic        mutual;
        logic [8:0]  tin_thr, tout_thr;
        logic [7:0]  tconfirm, rconfirm, tmax, drift_up, drift_dn;
        ctkt_pkg::t_node_st status_tbl [16];
        logic [7:0]  dwell_tbl [16];
        logic [15:0] ref_tbl [16];
        logic [15:0] comp_tbl [16];
        bit          started [16];
        ctkt_pkg::t_out_item expected_q [$];
        int          failures;

        function new();
            for (int i = 0; i < 16; i++) begin
                status_tbl[i] = ctkt_pkg::NS_CAL;
                dwell_tbl[i] = 8'd0;
                ref_tbl[i] = 16'd0;
                comp_tbl[i] = 16'd0;
                started[i] = 0;
            end
            mutual = 1'b0; tin_thr = 9'd20; tout_thr = 9'd10; tconfirm = 8'd3;
            rconfirm = 8'd3; tmax = 8'd200; drift_up = 8'd15; drift_dn = 8'd15;
            failures = 0;
        endfunction

        function void set_reg(ctkt_pkg::t_cfg_idx idx, logic [8:0] val);
            case (idx)
                ctkt_pkg::CFG_MUTUAL:   mutual = val[0];
                ctkt_pkg::CFG_TIN_THR:  tin_thr = val;
                ctkt_pkg::CFG_TOUT_THR: tout_thr = val;
                ctkt_pkg::CFG_TCONFIRM: tconfirm = val[7:0];
                ctkt_pkg::CFG_RCONFIRM: rconfirm = val[7:0];
                ctkt_pkg::CFG_TMAX:     tmax = val[7:0];
                ctkt_pkg::CFG_DRIFT_UP: drift_up = val[7:0];
                ctkt_pkg::CFG_DRIFT_DN: drift_dn = val[7:0];
                default: ;
            endcase
        endfunction

        // Compensation search by repeated subtraction, 8-bit wrapping fields.
        function ctkt_pkg::t_cal_rc comp_search(input logic [9:0] raw,
                                                inout logic [15:0] comp);
            logic [7:0] acc, fine, coarse, addr, rough, dir, ovf, hi, lo;
            int unsigned r;
            acc = {4'd0, comp[3:0]};
            fine = {4'd0, comp[7:4]};
            coarse = {4'd0, comp[11:8]};
            addr = {comp[15:14], 6'd0};
            rough = {6'd0, comp[13:12]};
            if (raw > 10'h1FF) begin
                r = raw - 10'h1FF;
                if (r < 10) return ctkt_pkg::CAL_DONE;
                if (mutual) begin
                    dir = 8'hFF; ovf = 8'hFA; r = r / 2;
                end else begin
                    dir = 8'd1; ovf = 8'd6;
                    if (r > 'h100 && addr < 8'hC0) begin
                        addr = addr + 8'h40; r = r - 'hF0;
                    end
                end
            end else begin
                r = 10'h1FF - raw;
                if (r < 10) return ctkt_pkg::CAL_DONE;
                if (mutual) begin
                    dir = 8'd1; ovf = 8'd6; r = r / 2;
                end else begin
                    dir = 8'hFF; ovf = 8'hFA;
                    if (r > 'h100 && addr >= 8'h40) begin
                        addr = addr - 8'h40; r = r - 'hF0;
                    end
                end
            end
            while (r > 1) begin
                while (r > 'hCF) begin
                    rough = rough + dir;
                    if (rough > 3) begin
                        rough = rough - dir;
                        break;
                    end
                    r = r - 'hCF;
                end
                while (r > 'h15) begin
                    coarse = coarse + dir;
                    if (coarse > 8'h0F) break;
                    r = r - 'h15;
                end
                if (coarse > 8'h0F) begin
                    rough = rough + dir;
                    if (rough > 3) begin
                        rough = rough - dir; coarse = coarse - dir;
                    end else coarse = coarse - ovf;
                end
                while (r > 1) begin
                    fine = fine + dir;
                    if (fine > 8'h0F) break;
                    r = r - 2;
                end
                if (fine > 8'h0F) begin
                    coarse = coarse + dir;
                    if (coarse > 8'h0F) begin
                        rough = rough + dir;
                        if (rough > 3) return ctkt_pkg::CAL_FAIL;
                        coarse = coarse - ovf;
                    end else fine = fine - ovf;
                end
            end
            hi = (rough << 4) | addr | coarse;
            lo = (fine << 4) | acc;
            comp = {hi, lo};
            return ctkt_pkg::CAL_BUSY;
        endfunction

        function void note_measurement(ctkt_pkg::t_in_item it);
            int n, d, tin, tout, refv;
            ctkt_pkg::t_node_st st, nst;
            ctkt_pkg::t_event ev;
            logic [7:0] dw;
            ctkt_pkg::t_cal_rc rc;
            logic [15:0] comp;
            ctkt_pkg::t_out_item e;
            n = it.node_index;
            if (!started[n]) begin
                started[n] = 1;
                comp_tbl[n] = mutual ? ctkt_pkg::COMP_MUTUAL : ctkt_pkg::COMP_SELF;
            end
            st = status_tbl[n];
            dw = dwell_tbl[n];
            refv = ref_tbl[n];
            d = int'(it.sensor_value) - refv;
            tin = tin_thr;
            tout = tout_thr;
            nst = st;
            ev = ctkt_pkg::EV_NONE;
            case (st)
                ctkt_pkg::NS_CAL: begin
                    comp = comp_tbl[n];
                    rc = comp_search(it.sensor_value, comp);
                    comp_tbl[n] = comp;
                    if (rc == ctkt_pkg::CAL_DONE) begin
                        ref_tbl[n] = {6'd0, it.sensor_value};
                        nst = ctkt_pkg::NS_IDLE; ev = ctkt_pkg::EV_CAL_DONE;
                    end else if (rc == ctkt_pkg::CAL_FAIL || dw > 10) begin
                        nst = ctkt_pkg::NS_ERR; ev = ctkt_pkg::EV_CAL_ERR;
                    end
                end
                ctkt_pkg::NS_RECAL: begin
                    if (d > -150) nst = ctkt_pkg::NS_IDLE;
                    else if (dw > 3) nst = ctkt_pkg::NS_CAL;
                end
                ctkt_pkg::NS_LOW: begin
                    if (d > 0) nst = ctkt_pkg::NS_IDLE;
                    else if (d < -150) nst = ctkt_pkg::NS_RECAL;
                    else if (dw > drift_dn) begin
                        ref_tbl[n] = ref_tbl[n] - 16'd1; nst = ctkt_pkg::NS_IDLE;
                    end
                end
                ctkt_pkg::NS_IDLE: begin
                    if (d < -150) nst = ctkt_pkg::NS_RECAL;
                    else if (d >= tin) nst = ctkt_pkg::NS_TIN;
                    else if (refv <= 512 - 150) nst = ctkt_pkg::NS_CAL;
                    else if (refv >= 512 + 150) nst = ctkt_pkg::NS_CAL;
                    else if (d < -1) nst = ctkt_pkg::NS_LOW;
                    else if (d > 1) nst = ctkt_pkg::NS_HIGH;
                end
                ctkt_pkg::NS_HIGH: begin
                    if (d < 0) nst = ctkt_pkg::NS_IDLE;
                    else if (d >= tin) nst = ctkt_pkg::NS_TIN;
                    else if (dw > drift_up) begin
                        ref_tbl[n] = ref_tbl[n] + 16'd1; nst = ctkt_pkg::NS_IDLE;
                    end
                end
                ctkt_pkg::NS_TIN: begin
                    if (dw >= tconfirm) begin
                        nst = ctkt_pkg::NS_TOUCH; ev = ctkt_pkg::EV_TOUCH;
                    end else if (d < tin) nst = ctkt_pkg::NS_IDLE;
                end
                ctkt_pkg::NS_TOUT: begin
                    if (dw >= rconfirm) begin
                        nst = ctkt_pkg::NS_IDLE; ev = ctkt_pkg::EV_RELEASE;
                    end else if (d > tin) nst = ctkt_pkg::NS_TOUCH;
                end
                ctkt_pkg::NS_TOUCH: begin
                    if (dw > tmax) nst = ctkt_pkg::NS_CAL;
                    else if (d < tout) nst = ctkt_pkg::NS_TOUT;
                end
                default: nst = ctkt_pkg::NS_ERR;
            endcase
            if (st != ctkt_pkg::NS_ERR && nst != ctkt_pkg::NS_ERR)
                dwell_tbl[n] = (nst != st) ? 8'd0 : dw + 8'd1;
            status_tbl[n] = nst;
            e.node_out = it.node_index;
            e.node_status = nst;
            e.event_code = ev;
            e.reference_out = ref_tbl[n];
            e.compensation_out = comp_tbl[n];
            e.touched = (nst == ctkt_pkg::NS_TOUCH || nst == ctkt_pkg::NS_TOUT);
            expected_q.push_back(e);
        endfunction

        function void check_result(ctkt_pkg::t_out_item got);
            ctkt_pkg::t_out_item e;
            if (expected_q.size() == 0) begin
                $error("unexpected result for node %0d", got.node_out);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got.node_out !== e.node_out) begin
                $error("node_out exp %0d got %0d", e.node_out, got.node_out); failures++;
            end
            if (got.node_status !== e.node_status) begin
                $error("node_status exp %0d got %0d", e.node_status, got.node_status);
                failures++;
            end
            if (got.event_code !== e.event_code) begin
                $error("event_code exp %0d got %0d", e.event_code, got.event_code);
                failures++;
            end
            if (got.reference_out !== e.reference_out) begin
                $error("reference_out exp %h got %h", e.reference_out, got.reference_out);
                failures++;
            end
            if (got.compensation_out !== e.compensation_out) begin
                $error("compensation_out exp %h got %h", e.compensation_out,
                       got.compensation_out);
                failures++;
            end
            if (got.touched !== e.touched) begin
                $error("touched exp %0d got %0d", e.touched, got.touched); failures++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    ctkt_pkg::t_in_item in_data = '0;
    logic        out_ready = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [8:0]  cfg_data = '0;
    logic        o_in_ready, o_out_valid;
    ctkt_pkg::t_out_item o_out_data;

    touch_scoreboard sb = new();
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    logic stall_req = 0;
    logic stall_seen = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;

    capacitive_touch_key_tracker uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_req && !stall_seen) begin
            stall_seen <= 1;
            stall_left <= 700;
            out_ready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 0;
        end else begin
            out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready)
            sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 30000) begin
            $display("capacitive_touch_key_tracker verification failed");
            $finish;
        end
    end

    task automatic send_measurement(input logic [3:0] node, input logic [9:0] value);
        ctkt_pkg::t_in_item it;
        it.node_index = node;
        it.sensor_value = value;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_measurement(it);
    endtask

    task automatic write_reg(input ctkt_pkg::t_cfg_idx idx, input logic [8:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        in_valid <= 0;
        cfg_we <= 0;
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic program_all(input logic [8:0] v [8]);
        for (int i = 0; i < 8; i++) write_reg(ctkt_pkg::t_cfg_idx'(i), v[i]);
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [9:0] random_reading();
        int k, v;
        k = $urandom_range(99);
        if (k < 50) v = 512 + $urandom_range(6) - 3;
        else if (k < 70) v = 512 + $urandom_range(120, 15);
        else if (k < 80) v = 512 - $urandom_range(60, 5);
        else if (k < 88) v = 512 - $urandom_range(300, 151);
        else if (k < 95) v = $urandom_range(1023);
        else v = $urandom_range(1) ? 1023 : 0;
        return v[9:0];
    endfunction

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
            send_measurement(4'($urandom_range(15)), random_reading());
    endtask

    initial begin
        logic [8:0] regs [8];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        regs = '{9'd0, 9'd20, 9'd10, 9'd3, 9'd3, 9'd200, 9'd15, 9'd15};
        program_all(regs);
        src_idle_pct = 26; snk_idle_pct = 84;
        send_measurement(4'd0, 10'd512);
        send_measurement(4'd1, 10'd0);
        send_measurement(4'd2, 10'd1023);
        send_measurement(4'd3, 10'd512);
        repeat (5) send_measurement(4'd3, 10'd600);
        repeat (4) send_measurement(4'd3, 10'd512);
        repeat (12) send_measurement(4'd4, 10'd0);
        send_measurement(4'd4, 10'd512);
        random_burst(110);
        drain();

        regs = '{9'd1, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
        program_all(regs);
        src_idle_pct = 84; snk_idle_pct = 26;
        random_burst(130);
        drain();

        regs = '{9'd0, 9'd511, 9'd511, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255};
        program_all(regs);
        src_idle_pct = 0; snk_idle_pct = 0;
        stall_req <= 1;
        random_burst(130);
        drain();

        regs = '{9'd1, 9'd30, 9'd15, 9'd5, 9'd2, 9'd40, 9'd4, 9'd4};
        program_all(regs);
        src_idle_pct = 26; snk_idle_pct = 84;
        random_burst(60);
        src_idle_pct = 0; snk_idle_pct = 0;
        random_burst(90);
        drain();

        if (sb.failures == 0)
            $display("capacitive_touch_key_tracker verification clean");
        else
            $display("capacitive_touch_key_tracker verification failed");
        $finish;
    end
endmodule
